// File: rtl/color_keyed_palette_blit_hmirror_macros.svh
// Assertion helpers shared by the blitter RTL.
// Both macros compile to nothing when SYNTHESIS is defined.
`ifndef COLOR_KEYED_PALETTE_BLIT_HMIRROR_MACROS_SVH
`define COLOR_KEYED_PALETTE_BLIT_HMIRROR_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, ignored while reset is asserted.
`define CKPB_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on every rising edge, reset cycles included.
`define CKPB_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CKPB_ASSERT(name, clk, rstn, prop, msg)
`define CKPB_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: rtl/ckpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ckpb_pkg;

    // Address width default and the range of the destination address field
    localparam int unsigned ADDR_BITS_DEFAULT = 24;
    localparam int unsigned DEST_ADDR_W       = 24;

    // Field widths
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned COLOR_W  = 16;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned CODE_W   = 8;

    // Stream widths
    localparam int unsigned S_TDATA_W = 96;
    localparam int unsigned S_TUSER_W = KIND_W;
    localparam int unsigned M_TDATA_W = DEST_ADDR_W + COLOR_W;

    // Palette
    localparam int unsigned PALETTE_DEPTH = 256;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PITCH_WORDS       = 1'b0,
        CFG_TRANSPARENT_INDEX = 1'b1
    } cfg_index_t;

    localparam logic [COORD_W-1:0] PITCH_RESET       = 16'd640;
    localparam logic [CODE_W-1:0]  TRANSPARENT_RESET = 8'd0;

    // Input beat kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PALETTE = 2'd0,
        KIND_START   = 2'd1,
        KIND_PIXEL   = 2'd2
    } kind_t;

    // Input beat after unpacking
    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] bitmap_width;
        logic [COORD_W-1:0] bitmap_height;
        logic [CODE_W-1:0]  pixel_code;
    } item_t;

endpackage

`default_nettype wire

// File: rtl/ckpb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ckpb_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/color_keyed_palette_blit_hmirror.sv
`timescale 1ns / 1ps
`default_nettype none
`include "color_keyed_palette_blit_hmirror_macros.svh"

// Color-keyed palette blitter with horizontal mirroring.
// Input stream s_*: tuser carries the beat kind (palette write, start, pixel),
// tdata the palette entry, start geometry or pixel code. Output stream m_*:
// one beat per pixel of a bitmap in progress, tdata holds address and color,
// tuser the write enable, tlast marks the final pixel of the bitmap.
// Palette and start beats, and pixels with no bitmap open, produce no beat.
// Config channel cfg_*: index 0 is the line pitch, index 1 the transparent
// code; write it only while the block is idle. cfg_ready is always high.
// Throughput: one input beat per cycle; a beat passes one working stage
// (palette RAM read plus counter and address update) and an output register.
// When m_tready is low the output register and the working stage fill and
// s_tready drops; nothing is lost. Reset clears the pipeline, the bitmap
// counters and the config registers (pitch 640, transparent code 0); the
// palette RAM is not cleared and must be loaded before its entries are used.
module color_keyed_palette_blit_hmirror #(
    parameter int unsigned ADDR_BITS = ckpb_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata: table_index[7:0], table_color[23:8], origin_x[39:24],
    //        origin_y[55:40], bitmap_width[71:56], bitmap_height[87:72],
    //        pixel_code[95:88]
    input  wire logic [ckpb_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: kind[1:0]
    input  wire logic [ckpb_pkg::S_TUSER_W-1:0]    s_tuser,
    // Output stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata: dest_address[23:0], pixel_color[39:24]
    output logic      [ckpb_pkg::M_TDATA_W-1:0]    m_tdata,
    // tuser: write_enable[0]
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    // Configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ckpb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ckpb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import ckpb_pkg::*;

    // Configuration registers
    logic [COORD_W-1:0]   pitch_reg;
    logic [CODE_W-1:0]    transparent_reg;

    // Working stage
    logic                 s1_valid_reg, s1_valid_next;
    item_t                s1_item_reg;
    item_t                in_item;

    // Bitmap state
    logic [ADDR_BITS-1:0] row_base_reg, row_base_next;
    logic [COORD_W-1:0]   column_count_reg, column_count_next;
    logic [COORD_W-1:0]   row_count_reg, row_count_next;
    logic [COORD_W-1:0]   width_held_reg, width_held_next;
    logic [COORD_W-1:0]   height_held_reg, height_held_next;
    logic                 active_reg, active_next;

    // Output register
    logic                   m_valid_reg, m_valid_next;
    logic [DEST_ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [COLOR_W-1:0]     m_color_reg, m_color_next;
    logic                   m_we_reg, m_we_next;
    logic                   m_last_reg, m_last_next;

    logic                 s_accept;
    logic                 s1_fire;
    logic [COLOR_W-1:0]   palette_color;
    logic [2*COORD_W-1:0] start_product;
    logic [2*COORD_W-1:0] start_sum;
    logic [COORD_W-1:0]   mirror_col;
    logic [ADDR_BITS-1:0] pixel_addr;
    logic                 row_end;
    logic                 last_pixel;
    logic                 opaque;
    logic                 emit;

    // Unpack the input beat
    assign in_item.kind          = kind_t'(s_tuser);
    assign in_item.origin_x      = s_tdata[39:24];
    assign in_item.origin_y      = s_tdata[55:40];
    assign in_item.bitmap_width  = s_tdata[71:56];
    assign in_item.bitmap_height = s_tdata[87:72];
    assign in_item.pixel_code    = s_tdata[95:88];

    // Handshakes
    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Palette: write on accepted palette beats, read on accepted pixel beats
    ckpb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (s_accept && (in_item.kind == KIND_PALETTE)),
        .wr_addr (s_tdata[7:0]),
        .wr_data (s_tdata[23:8]),
        .rd_en   (s_accept && (in_item.kind == KIND_PIXEL)),
        .rd_addr (in_item.pixel_code),
        .rd_data (palette_color)
    );

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg       <= PITCH_RESET;
            transparent_reg <= TRANSPARENT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PITCH_WORDS:       pitch_reg       <= cfg_data;
                CFG_TRANSPARENT_INDEX: transparent_reg <= cfg_data[CODE_W-1:0];
                default:               pitch_reg       <= pitch_reg;
            endcase
        end
    end

    // Pixel arithmetic in the working stage
    assign start_product = s1_item_reg.origin_y * pitch_reg;
    assign start_sum     = start_product + (2*COORD_W)'(s1_item_reg.origin_x);
    assign mirror_col    = width_held_reg - COORD_W'(1) - column_count_reg;
    assign pixel_addr    = row_base_reg + ADDR_BITS'(mirror_col);
    assign row_end       = ((COORD_W+1)'(column_count_reg) + (COORD_W+1)'(1))
                           == (COORD_W+1)'(width_held_reg);
    assign last_pixel    = row_end
                           && (((COORD_W+1)'(row_count_reg) + (COORD_W+1)'(1))
                               == (COORD_W+1)'(height_held_reg));
    assign opaque        = s1_item_reg.pixel_code != transparent_reg;
    assign emit          = (s1_item_reg.kind == KIND_PIXEL) && active_reg;

    // Next state of the stage, bitmap counters and output register
    always_comb begin
        s1_valid_next     = s1_valid_reg;
        row_base_next     = row_base_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        width_held_next   = width_held_reg;
        height_held_next  = height_held_reg;
        active_next       = active_reg;
        m_valid_next      = m_valid_reg;
        m_addr_next       = m_addr_reg;
        m_color_next      = m_color_reg;
        m_we_next         = m_we_reg;
        m_last_next       = m_last_reg;

        // Drain the output register when taken
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (s1_fire) begin
            s1_valid_next = 1'b0;
            unique case (s1_item_reg.kind)
                KIND_START: begin
                    width_held_next   = s1_item_reg.bitmap_width;
                    height_held_next  = s1_item_reg.bitmap_height;
                    row_base_next     = start_sum[ADDR_BITS-1:0];
                    column_count_next = '0;
                    row_count_next    = '0;
                    active_next       = (s1_item_reg.bitmap_width != '0)
                                        && (s1_item_reg.bitmap_height != '0);
                end
                KIND_PIXEL: begin
                    if (active_reg) begin
                        m_valid_next = 1'b1;
                        m_addr_next  = DEST_ADDR_W'(pixel_addr);
                        m_color_next = opaque ? palette_color : '0;
                        m_we_next    = opaque;
                        m_last_next  = last_pixel;
                        // Advance column, wrap to the next line at row end
                        if (row_end) begin
                            column_count_next = '0;
                            row_count_next    = row_count_reg + COORD_W'(1);
                            row_base_next     = row_base_reg + ADDR_BITS'(pitch_reg);
                            if (last_pixel) begin
                                active_next = 1'b0;
                            end
                        end else begin
                            column_count_next = column_count_reg + COORD_W'(1);
                        end
                    end
                end
                default: begin
                    active_next = active_reg;
                end
            endcase
        end

        // Load a new beat into the stage
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            row_base_reg     <= '0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            width_held_reg   <= '0;
            height_held_reg  <= '0;
            active_reg       <= 1'b0;
        end else begin
            s1_valid_reg     <= s1_valid_next;
            m_valid_reg      <= m_valid_next;
            row_base_reg     <= row_base_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            width_held_reg   <= width_held_next;
            height_held_reg  <= height_held_next;
            active_reg       <= active_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= in_item;
        end
        m_addr_reg  <= m_addr_next;
        m_color_reg <= m_color_next;
        m_we_reg    <= m_we_next;
        m_last_reg  <= m_last_next;
    end

    // Output stream
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_color_reg, m_addr_reg};
    assign m_tuser  = m_we_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    `CKPB_ASSERT(a_stall_only_when_full, aclk, aresetn, !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready), "input stalled while pipeline has room")
    `CKPB_ASSERT(a_column_in_range, aclk, aresetn, active_reg |-> (column_count_reg < width_held_reg), "column counter past bitmap width")
    `CKPB_ASSERT(a_last_closes_bitmap, aclk, aresetn, (s1_fire && emit && last_pixel) |=> !active_reg, "bitmap still open after its last pixel")
    `CKPB_ASSERT(a_transparent_no_color, aclk, aresetn, (m_valid_reg && !m_we_reg) |-> (m_color_reg == '0), "skipped pixel carries a color")
    `CKPB_ASSERT_ALWAYS(a_reset_empties_output, aclk, !aresetn |=> (!m_valid_reg && !s1_valid_reg), "pipeline not empty after reset")

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import ckpb_pkg::*;

    localparam int unsigned ADDR_W = 24;

    // Field offsets inside s_tdata
    localparam int unsigned IDX_LO   = 0;
    localparam int unsigned COLOR_LO = 8;
    localparam int unsigned OX_LO    = 24;
    localparam int unsigned OY_LO    = 40;
    localparam int unsigned W_LO     = 56;
    localparam int unsigned H_LO     = 72;
    localparam int unsigned CODE_LO  = 88;

    // The one kind code the block has no use for
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [S_TDATA_W-1:0] data;
        bit                   drain_first;
    } blit_beat_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } dest_write_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Beats waiting to be driven, and destination writes still owed by the block
    blit_beat_t  pending_beats[$];
    dest_write_t dest_writes_due[$];
    blit_beat_t  cur_beat;
    int          beats_taken = 0;
    int          mismatches  = 0;
    wire         calm = (beats_taken >= 300) && (beats_taken < 450);

    // Blitter state as the block should hold it
    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [ADDR_W-1:0]  base_addr = '0;
    logic [COORD_W-1:0] col_pos   = '0;
    logic [COORD_W-1:0] row_pos   = '0;
    logic [COORD_W-1:0] w_cur     = '0;
    logic [COORD_W-1:0] h_cur     = '0;
    logic               drawing   = 1'b0;
    logic [COORD_W-1:0] pitch_cfg = PITCH_RESET;
    logic [CODE_W-1:0]  key_cfg   = TRANSPARENT_RESET;

    // Palette codes loaded so far, so that pixels only read loaded entries
    logic [CODE_W-1:0] loaded_codes[$];
    bit                loaded[PALETTE_DEPTH];

    logic [CFG_DATA_W-1:0] pitch_set[5];
    logic [CFG_DATA_W-1:0] key_set[5];

    color_keyed_palette_blit_hmirror #(
        .ADDR_BITS(ADDR_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [S_TDATA_W-1:0] noise();
        return {$urandom, $urandom, $urandom};
    endfunction

    function automatic void add_palette(logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] color);
        blit_beat_t b;
        b.kind = KIND_PALETTE;
        b.data = noise();
        b.data[IDX_LO +: INDEX_W] = idx;
        b.data[COLOR_LO +: COLOR_W] = color;
        b.drain_first = 1'b0;
        pending_beats.push_back(b);
        if (!loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_codes.push_back(idx);
        end
    endfunction

    function automatic void add_start(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
                                      logic [COORD_W-1:0] w, logic [COORD_W-1:0] h,
                                      bit hold);
        blit_beat_t b;
        b.kind = KIND_START;
        b.data = noise();
        b.data[OX_LO +: COORD_W] = ox;
        b.data[OY_LO +: COORD_W] = oy;
        b.data[W_LO +: COORD_W] = w;
        b.data[H_LO +: COORD_W] = h;
        b.drain_first = hold;
        pending_beats.push_back(b);
    endfunction

    function automatic void add_pixel(logic [CODE_W-1:0] code);
        blit_beat_t b;
        b.kind = KIND_PIXEL;
        b.data = noise();
        b.data[CODE_LO +: CODE_W] = code;
        b.drain_first = 1'b0;
        pending_beats.push_back(b);
    endfunction

    function automatic void add_unused();
        blit_beat_t b;
        b.kind = KIND_UNUSED;
        b.data = noise();
        b.drain_first = 1'b0;
        pending_beats.push_back(b);
    endfunction

    // Transparent code now and then, else a code whose palette entry is loaded
    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(0, 3) == 0)
            return key_cfg;
        return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
    endfunction

    function automatic logic [COORD_W-1:0] pick_origin();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Advance the expected blitter state by one accepted beat
    function automatic void blit_predict(blit_beat_t b);
        logic [47:0]        prod;
        logic [COORD_W-1:0] col;
        logic               row_end;
        logic               last_px;
        logic [CODE_W-1:0]  code;
        dest_write_t        wr;
        case (b.kind)
            KIND_PALETTE: begin
                pal_mem[b.data[IDX_LO +: INDEX_W]] = b.data[COLOR_LO +: COLOR_W];
            end
            KIND_START: begin
                w_cur = b.data[W_LO +: COORD_W];
                h_cur = b.data[H_LO +: COORD_W];
                prod = {32'd0, b.data[OY_LO +: COORD_W]} * {32'd0, pitch_cfg};
                base_addr = prod[ADDR_W-1:0] + {8'd0, b.data[OX_LO +: COORD_W]};
                col_pos = '0;
                row_pos = '0;
                drawing = (w_cur != 0) && (h_cur != 0);
            end
            KIND_PIXEL: begin
                if (drawing) begin
                    code = b.data[CODE_LO +: CODE_W];
                    col = w_cur - 16'd1 - col_pos;
                    row_end = ({1'b0, col_pos} + 17'd1) == {1'b0, w_cur};
                    last_px = row_end && (({1'b0, row_pos} + 17'd1) == {1'b0, h_cur});
                    wr.we = (code != key_cfg);
                    wr.addr = base_addr + {8'd0, col};
                    wr.color = wr.we ? pal_mem[code] : '0;
                    wr.last = last_px;
                    dest_writes_due.push_back(wr);
                    // Move to the next source pixel, wrapping to the next line
                    if (row_end) begin
                        col_pos = '0;
                        row_pos = row_pos + 16'd1;
                        base_addr = base_addr + {8'd0, pitch_cfg};
                        if (last_px)
                            drawing = 1'b0;
                    end else begin
                        col_pos = col_pos + 16'd1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < 200)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Random traffic: mostly whole bitmaps, with loads, empty and broken bitmaps mixed in
    task automatic queue_random_phase(int target, bit hold_once);
        int                 made;
        int                 pick;
        int                 n;
        bit                 big;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                add_palette(INDEX_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 65535)));
                made++;
            end else if (pick < 82) begin
                big = ($urandom_range(0, 19) == 0);
                w = big ? COORD_W'($urandom_range(1, 65535)) : COORD_W'($urandom_range(1, 6));
                h = big ? COORD_W'($urandom_range(1, 65535)) : COORD_W'($urandom_range(1, 4));
                add_start(pick_origin(), pick_origin(), w, h,
                          hold_once || ($urandom_range(0, 99) == 0));
                hold_once = 1'b0;
                n = big ? $urandom_range(1, 5) : int'(w) * int'(h);
                // Cut some bitmaps short so the next start abandons them
                if (!big && $urandom_range(0, 9) == 0)
                    n = $urandom_range(0, n - 1);
                repeat (n) add_pixel(pick_code());
                made += n + 1;
                // Extra pixels after the bitmap's queued ones, past its end if it was not cut short
                if (!big && $urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 2)) add_pixel(pick_code());
            end else if (pick < 90) begin
                if ($urandom_range(0, 1) == 0)
                    add_start(pick_origin(), pick_origin(), '0,
                              COORD_W'($urandom_range(0, 65535)), 1'b0);
                else
                    add_start(pick_origin(), pick_origin(),
                              COORD_W'($urandom_range(0, 65535)), '0, 1'b0);
                made++;
                repeat ($urandom_range(0, 2)) add_pixel(pick_code());
            end else if (pick < 95) begin
                add_unused();
            end else begin
                add_pixel(pick_code());
            end
        end
    endtask

    // Hold until every beat is in and every write has come out, then let the pipe settle
    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_tvalid || dest_writes_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_PITCH_WORDS:       pitch_cfg = value;
            CFG_TRANSPARENT_INDEX: key_cfg = value[CODE_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Input driver: take the accepted beat into the prediction, then present the next one
    always @(posedge aclk) begin : drive_input
        bit stall;
        stall = !calm && ($urandom_range(0, 99) < 7);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                blit_predict(cur_beat);
                beats_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && !stall &&
                    !(pending_beats[0].drain_first && dest_writes_due.size() != 0)) begin
                    cur_beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_beat.kind;
                    s_tdata <= cur_beat.data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output backpressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 7);
    end

    // Output monitor: check each write beat against the oldest one owed
    always @(posedge aclk) begin : watch_output
        dest_write_t wr;
        if (aresetn && m_tvalid && m_tready) begin
            if (dest_writes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected write beat addr %h", m_tdata[ADDR_W-1:0]));
            end else begin
                wr = dest_writes_due.pop_front();
                if (m_tuser !== wr.we)
                    report_mismatch($sformatf("write_enable %b, want %b", m_tuser, wr.we));
                if (m_tdata[ADDR_W-1:0] !== wr.addr)
                    report_mismatch($sformatf("dest_address %h, want %h",
                                              m_tdata[ADDR_W-1:0], wr.addr));
                if (m_tdata[ADDR_W +: COLOR_W] !== wr.color)
                    report_mismatch($sformatf("pixel_color %h, want %h",
                                              m_tdata[ADDR_W +: COLOR_W], wr.color));
                if (m_tlast !== wr.last)
                    report_mismatch($sformatf("last_pixel %b, want %b", m_tlast, wr.last));
            end
        end
    end

    initial begin
        pitch_set[0] = 16'd0;
        key_set[0]   = 16'h00FF;
        pitch_set[1] = 16'hFFFF;
        key_set[1]   = 16'hA55A;
        pitch_set[2] = 16'd1;
        key_set[2]   = 16'hFF00;
        pitch_set[3] = CFG_DATA_W'($urandom_range(0, 65535));
        key_set[3]   = CFG_DATA_W'($urandom_range(0, 65535));
        pitch_set[4] = 16'd640;
        key_set[4]   = 16'h0080;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Palette extremes
        add_palette(8'h00, 16'hFFFF);
        add_palette(8'hFF, 16'h0000);
        add_palette(8'h55, 16'hA5A5);
        add_palette(8'hAA, 16'h5A5A);
        add_palette(8'h01, 16'h1234);
        // Pixel with no bitmap open, and the unused kind
        add_pixel(8'hFF);
        add_unused();
        // Empty bitmap, then a pixel that must be dropped
        add_start(16'd5, 16'd5, 16'd0, 16'd5, 1'b0);
        add_pixel(8'h55);
        // Small mirrored bitmap with a transparent code in it
        add_start(16'd10, 16'd20, 16'd3, 16'd2, 1'b0);
        add_pixel(8'h00);
        add_pixel(8'hFF);
        add_pixel(8'h55);
        add_pixel(8'hAA);
        add_pixel(8'h01);
        add_pixel(8'hFF);
        // Address wrap from the far corner
        add_start(16'hFFFF, 16'hFFFF, 16'd2, 16'd1, 1'b0);
        add_pixel(8'h01);
        add_pixel(8'hAA);
        // Largest bitmap, abandoned by a restart, then a pixel past the end
        add_start(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        add_pixel(8'h55);
        add_pixel(8'hAA);
        add_start(16'h1234, 16'd7, 16'd1, 16'd1, 1'b0);
        add_pixel(8'hFF);
        add_pixel(8'h01);

        queue_random_phase(130, 1'b0);
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            write_reg(CFG_PITCH_WORDS, pitch_set[p]);
            write_reg(CFG_TRANSPARENT_INDEX, key_set[p]);
            @(negedge aclk);
            queue_random_phase(130, p == 1);
        end
        wait_idle();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/ckpb_pkg.sv
rtl/ckpb_ram.sv
rtl/color_keyed_palette_blit_hmirror.sv
sim/tb.sv
